### design/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
`timescale 1ns / 1ps

package uer_pkg;

  // configuration port shape
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // register field widths
  localparam int unsigned FIRE_W  = 20;
  localparam int unsigned TRIG_W  = 8;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned RANGE_W = 10;
  localparam int unsigned STAT_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_INVERT   = 3'd4;

  // register reset values
  localparam logic [FIRE_W-1:0]  FIRE_INTERVAL_RST = 20'd60000;
  localparam logic [TRIG_W-1:0]  TRIGGER_WIDTH_RST = 8'd11;
  localparam logic [DIV_W-1:0]   TICKS_PER_CM_RST  = 8'd59;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST     = 10'd400;

  // range status codes
  localparam logic [STAT_W-1:0] STAT_VALID        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OUT_OF_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_HW_FAIL      = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_FIN
  } state_e;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### design/uer_divider.sv
// restoring divider, one quotient bit per clock
`timescale 1ns / 1ps

module uer_divider import uer_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]      divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output div_status_t           status_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W);
  localparam logic [CntW-1:0] LastStep = CntW'(DIVIDEND_W - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_sub;
  logic           fits;

  // shared subtract and compare
  assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign fits    = (rem_sh >= {1'b0, divisor_i});

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = LastStep;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

### design/ultrasonic_echo_ranger.sv
// ultrasonic echo ranger top level: echo timing, settling and trigger drive
`timescale 1ns / 1ps

// channel   direction  transaction
// in        input      echo_level_i, one per microsecond tick
// out       output     trigger_level_o, distance_cm_o, range_status_o, result_updated_o
// cfg       input      cfg_we_i, cfg_idx_i, cfg_data_i, plain register write
//
// a tick passes the calc and fin states; a settle tick with an echo in the window
// also waits in the div state while the restoring divider retires one bit a clock
// reset sets the registers to their defaults and the window as if an echo was seen
// in_ready_o is low while a tick is in work or a result waits unclaimed
// a result is held in the output register until out_ready_i takes it

module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // tick input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  echo_level_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  trigger_level_o,
  output logic [RANGE_W-1:0]    distance_cm_o,
  output logic [STAT_W-1:0]     range_status_o,
  output logic                  result_updated_o
);

  localparam int unsigned CmpW = (COUNT_BITS > FIRE_W) ? COUNT_BITS : FIRE_W;

  // configuration registers
  logic [FIRE_W-1:0]  fire_q;
  logic [TRIG_W-1:0]  trig_width_q;
  logic [DIV_W-1:0]   tpc_q;
  logic [RANGE_W-1:0] max_range_q;
  logic               trig_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_q       <= FIRE_INTERVAL_RST;
      trig_width_q <= TRIGGER_WIDTH_RST;
      tpc_q        <= TICKS_PER_CM_RST;
      max_range_q  <= MAX_RANGE_RST;
      trig_inv_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIRE_INTERVAL: fire_q       <= cfg_data_i[FIRE_W-1:0];
        REG_TRIGGER_WIDTH: trig_width_q <= cfg_data_i[TRIG_W-1:0];
        REG_TICKS_PER_CM:  tpc_q        <= cfg_data_i[DIV_W-1:0];
        REG_MAX_RANGE:     max_range_q  <= cfg_data_i[RANGE_W-1:0];
        REG_TRIG_INVERT:   trig_inv_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ranger state
  state_e                state_q, state_d;
  logic                  prev_echo_q, prev_echo_d;
  logic [COUNT_BITS-1:0] run_q, run_d;
  logic [COUNT_BITS-1:0] width_q, width_d;
  logic [COUNT_BITS-1:0] ticks_q, ticks_d;
  logic                  win_q, win_d;
  logic                  settle_q, settle_d;
  logic [RANGE_W-1:0]    held_dist_q, held_dist_d;
  logic [STAT_W-1:0]     held_stat_q, held_stat_d;
  logic [TRIG_W-1:0]     trig_rem_q, trig_rem_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_trig_q, out_trig_d;
  logic [RANGE_W-1:0] out_dist_q, out_dist_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic               out_upd_q, out_upd_d;

  // divider hookup
  logic                  div_start;
  logic [DIV_W-1:0]      divisor;
  logic [COUNT_BITS-1:0] quotient;
  div_status_t           div_status;

  logic                  in_fire;
  logic [COUNT_BITS-1:0] ticks_inc;
  logic [COUNT_BITS-1:0] run_inc;
  logic                  ticks_le_fire;
  logic [TRIG_W-1:0]     trig_base;
  logic                  trig_active;

  assign divisor = (tpc_q == '0) ? DIV_W'(1) : tpc_q;

  uer_divider #(
    .DIVIDEND_W (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (width_q),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  // saturating counts and window compare
  assign ticks_inc     = (ticks_q == '1) ? ticks_q : ticks_q + COUNT_BITS'(1);
  assign run_inc       = (run_q == '1) ? run_q : run_q + COUNT_BITS'(1);
  assign ticks_le_fire = (CmpW'(ticks_inc) <= CmpW'(fire_q));

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // trigger pulse for the finishing tick
  assign trig_base   = settle_q ? trig_width_q : trig_rem_q;
  assign trig_active = (trig_base != '0);

  // sequencer and next state
  always_comb begin
    state_d     = state_q;
    prev_echo_d = prev_echo_q;
    run_d       = run_q;
    width_d     = width_q;
    ticks_d     = ticks_q;
    win_d       = win_q;
    settle_d    = settle_q;
    held_dist_d = held_dist_q;
    held_stat_d = held_stat_q;
    trig_rem_d  = trig_rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_trig_d  = out_trig_q;
    out_dist_d  = out_dist_q;
    out_stat_d  = out_stat_q;
    out_upd_d   = out_upd_q;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ticks_d     = ticks_inc;
          prev_echo_d = echo_level_i;
          settle_d    = (CmpW'(ticks_inc) > CmpW'(fire_q));
          priority if (echo_level_i && !prev_echo_q) begin
            run_d = COUNT_BITS'(1);
          end else if (echo_level_i) begin
            run_d = run_inc;
          end else if (prev_echo_q && run_q != '0) begin
            width_d = run_q;
            win_d   = ticks_le_fire;
          end
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (settle_q && win_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (settle_q) begin
          if (!win_q) begin
            held_stat_d = STAT_HW_FAIL;
          end else if (quotient > COUNT_BITS'(max_range_q)) begin
            held_stat_d = STAT_OUT_OF_RANGE;
          end else begin
            held_dist_d = quotient[RANGE_W-1:0];
            held_stat_d = STAT_VALID;
          end
          ticks_d = '0;
          win_d   = 1'b0;
        end
        trig_rem_d  = trig_active ? trig_base - TRIG_W'(1) : '0;
        out_valid_d = 1'b1;
        out_trig_d  = trig_active ^ trig_inv_q;
        out_dist_d  = (held_stat_d == STAT_VALID) ? held_dist_d : '0;
        out_stat_d  = held_stat_d;
        out_upd_d   = settle_q;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_echo_q <= 1'b0;
      run_q       <= '0;
      width_q     <= '0;
      ticks_q     <= '0;
      win_q       <= 1'b1;
      settle_q    <= 1'b0;
      held_dist_q <= '0;
      held_stat_q <= STAT_OUT_OF_RANGE;
      trig_rem_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_echo_q <= prev_echo_d;
      run_q       <= run_d;
      width_q     <= width_d;
      ticks_q     <= ticks_d;
      win_q       <= win_d;
      settle_q    <= settle_d;
      held_dist_q <= held_dist_d;
      held_stat_q <= held_stat_d;
      trig_rem_q  <= trig_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_trig_q <= out_trig_d;
    out_dist_q <= out_dist_d;
    out_stat_q <= out_stat_d;
    out_upd_q  <= out_upd_d;
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_level_o  = out_trig_q;
  assign distance_cm_o    = out_dist_q;
  assign range_status_o   = out_stat_q;
  assign result_updated_o = out_upd_q;

`ifndef SYNTHESIS
  // an accepted tick always moves the sequencer out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_CALC)
    else $error("accepted tick did not start work");

  // distance reads zero unless the status says valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_status_o != STAT_VALID |-> distance_cm_o == '0)
    else $error("distance shown with non-valid status");

  // status is one of the three defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> range_status_o == STAT_VALID ||
      range_status_o == STAT_OUT_OF_RANGE || range_status_o == STAT_HW_FAIL)
    else $error("undefined range status");

  // divider only runs while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.busy |-> state_q == ST_DIV)
    else $error("divider busy outside divide state");
`endif

endmodule
